FILE: rtl/pcru_pkg.sv
// Package with the constants, codes and transaction types of the power control register unit.
package pcru_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned AddrW = 32;
  localparam int unsigned SizeW = 2;
  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 4;

  localparam logic [AddrW-1:0] RegAddr     = 32'h10C0_01C4;
  localparam logic [DataW-1:0] WriteMask   = 32'h1E00_FFBF;
  localparam logic [DataW-1:0] BitPwrOk    = 32'h2000_0000;
  localparam int unsigned      PwrIntPos   = 30;
  localparam int unsigned      TimerLsb    = 12;
  localparam int unsigned      TimerEnPos  = 11;
  localparam logic [DataW-1:0] BitForceOff = 32'h0000_0200;
  localparam logic [DataW-1:0] BitCold     = 32'h0000_0004;
  localparam logic [DataW-1:0] BitChipSel  = 32'h0000_0002;
  localparam logic [DataW-1:0] BitVccOn    = 32'h0000_0001;
  localparam logic [DataW-1:0] CtrlReset   = BitCold;

  typedef enum logic [OpW-1:0] {
    OP_READ       = 3'd0,
    OP_WRITE      = 3'd1,
    OP_POWER_UP   = 3'd2,
    OP_LATCH_COLD = 3'd3,
    OP_LATCH_WARM = 3'd4,
    OP_APPLY_RST  = 3'd5,
    OP_TICK       = 3'd6,
    OP_WATCHDOG   = 3'd7
  } op_e;

  typedef enum logic [SizeW-1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_e;

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_WARM = 2'd1,
    CAUSE_COLD = 2'd2
  } cause_e;

  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] access_size;
    logic [DataW-1:0] write_data;
    logic             power_interrupt_line;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             access_error;
    logic             enter_deep_sleep;
    logic             stop_timer_interrupt;
  } res_item_t;

endpackage

FILE: rtl/pcru_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface pcru_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcru_pkg::OpW-1:0]    operation;
  logic [pcru_pkg::AddrW-1:0]  address;
  logic [pcru_pkg::SizeW-1:0]  access_size;
  logic [pcru_pkg::DataW-1:0]  write_data;
  logic                        power_interrupt_line;

  modport source (output valid, operation, address, access_size, write_data,
                  power_interrupt_line, input ready);
  modport sink (input valid, operation, address, access_size, write_data,
                power_interrupt_line, output ready);
endinterface

interface pcru_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcru_pkg::DataW-1:0]  read_data;
  logic                        access_error;
  logic                        enter_deep_sleep;
  logic                        stop_timer_interrupt;

  modport source (output valid, read_data, access_error, enter_deep_sleep,
                  stop_timer_interrupt, input ready);
  modport sink (input valid, read_data, access_error, enter_deep_sleep,
                stop_timer_interrupt, output ready);
endinterface

FILE: rtl/pcru_in_reg.sv
// Input register stage that captures one transaction and holds it until it moves on.
module pcru_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  pcru_in_if.sink            in_i,
  input  logic               advance_i,
  output logic               valid_o,
  output pcru_pkg::in_item_t item_o
);
  import pcru_pkg::*;

  logic     valid_d, valid_q;
  in_item_t item_q;
  logic     load;

  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.operation            <= in_i.operation;
      item_q.address              <= in_i.address;
      item_q.access_size          <= in_i.access_size;
      item_q.write_data           <= in_i.write_data;
      item_q.power_interrupt_line <= in_i.power_interrupt_line;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/pcru_core.sv
// Register state and the single-pass update logic for one transaction.
module pcru_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  pcru_pkg::in_item_t  item_i,
  output pcru_pkg::res_item_t result_o
);
  import pcru_pkg::*;

  logic [DataW-1:0] ctrl_d, ctrl_q;
  cause_e           cause_d, cause_q;
  logic             armed_d, armed_q;
  logic [CntW-1:0]  ticks_d, ticks_q;

  logic             good;
  logic [DataW-1:0] wr_word;
  logic             prev_on, next_on;
  logic [CntW-1:0]  wr_count;

  assign good = (item_i.address == RegAddr) && (item_i.access_size == SIZE_WORD);
  assign wr_word  = item_i.write_data & WriteMask;
  assign prev_on  = |(ctrl_q & (BitVccOn | BitChipSel));
  assign next_on  = |(wr_word & (BitVccOn | BitChipSel));
  assign wr_count = wr_word[TimerLsb +: CntW];

  always_comb begin
    ctrl_d   = ctrl_q;
    cause_d  = cause_q;
    armed_d  = armed_q;
    ticks_d  = ticks_q;
    result_o = '0;
    case (op_e'(item_i.operation))
      OP_READ: begin
        if (good) begin
          result_o.read_data = ctrl_q | BitPwrOk;
          result_o.read_data[PwrIntPos] = item_i.power_interrupt_line;
        end else begin
          result_o.access_error = 1'b1;
        end
      end
      OP_WRITE: begin
        if (good) begin
          ctrl_d = wr_word;
          result_o.enter_deep_sleep = prev_on && !next_on;
          if (wr_word[TimerEnPos] && !ctrl_q[TimerEnPos]) begin
            ticks_d = wr_count;
            if (wr_count == '0) begin
              armed_d = 1'b0;
              result_o.stop_timer_interrupt = 1'b1;
            end else begin
              armed_d = 1'b1;
            end
          end else if (!wr_word[TimerEnPos] && ctrl_q[TimerEnPos]) begin
            armed_d = 1'b0;
          end
        end else begin
          result_o.access_error = 1'b1;
        end
      end
      OP_POWER_UP: begin
        ctrl_d = ctrl_q | BitForceOff | BitChipSel | BitVccOn;
      end
      OP_LATCH_COLD: begin
        cause_d = CAUSE_COLD;
      end
      OP_LATCH_WARM: begin
        cause_d = CAUSE_WARM;
      end
      OP_APPLY_RST: begin
        case (cause_q)
          CAUSE_COLD: ctrl_d = ctrl_q | BitCold;
          CAUSE_WARM: ctrl_d = ctrl_q & ~BitCold;
          default:    result_o.access_error = 1'b1;
        endcase
        cause_d = CAUSE_NONE;
      end
      OP_TICK: begin
        if (armed_q) begin
          if (ticks_q <= CntW'(1)) begin
            ticks_d = '0;
            armed_d = 1'b0;
            result_o.stop_timer_interrupt = 1'b1;
          end else begin
            ticks_d = ticks_q - CntW'(1);
          end
        end
      end
      default: begin
        result_o.access_error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= CtrlReset;
      cause_q <= CAUSE_NONE;
      armed_q <= 1'b0;
      ticks_q <= '0;
    end else if (fire_i) begin
      ctrl_q  <= ctrl_d;
      cause_q <= cause_d;
      armed_q <= armed_d;
      ticks_q <= ticks_d;
    end
  end

endmodule

FILE: rtl/power_control_register_unit.sv
// Top level of the power control register unit with its result register.
//
// The unit holds one 32-bit power control register together with its reset
// cause latch and a four-bit stop timer. Transactions arrive on the in_i
// channel, one operation each (read, write, power up, cause latch, apply
// reset, tick or watchdog, the last answered with an access error), and each
// produces exactly one result transaction on the out_o channel.
// A transaction is captured in the input register, evaluated by the update
// logic once the result register is free or being emptied, and stored in the
// result register together with the new register state.
// One transaction is accepted in every cycle while the receiver takes every
// result; the rate is set by the single pass through the update logic between
// the two registers.
// Reset clears both stages and loads the register with only the cold-start
// bit set, no latched cause and the timer disarmed.
// When the receiver stalls, the result register holds its transaction and the
// input register can still take one more, after which in_i.ready falls.
module power_control_register_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcru_in_if.sink   in_i,
  pcru_out_if.source out_o
);
  import pcru_pkg::*;

  logic      stage_valid;
  in_item_t  stage_item;
  logic      advance;
  logic      fire;
  res_item_t result;

  logic      out_valid_d, out_valid_q;
  res_item_t res_q;

  assign advance = !out_valid_q || out_o.ready;
  assign fire    = stage_valid && advance;

  pcru_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  pcru_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= result;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.read_data            = res_q.read_data;
  assign out_o.access_error         = res_q.access_error;
  assign out_o.enter_deep_sleep     = res_q.enter_deep_sleep;
  assign out_o.stop_timer_interrupt = res_q.stop_timer_interrupt;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the power control register unit, with its scoreboard class.
module testbench;
  import pcru_pkg::*;

  localparam int unsigned TotalTxns     = 1125;
  localparam int unsigned CalmTxns      = 150;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit   = 10;

  class pcru_scoreboard;
    logic [DataW-1:0] ctrl_word;
    cause_e           cause;
    bit               armed;
    logic [CntW-1:0]  ticks_left;
    res_item_t        expected_results[$];
    int unsigned      faults;

    function new();
      ctrl_word  = CtrlReset;
      cause      = CAUSE_NONE;
      armed      = 1'b0;
      ticks_left = '0;
      faults     = 0;
    endfunction

    function void report_fault(string msg);
      faults++;
      if (faults <= ReportLimit) begin
        $display("%s", msg);
      end
    endfunction

    function res_item_t next_power_result(in_item_t it);
      res_item_t        r;
      logic [DataW-1:0] prev;
      logic [DataW-1:0] nxt;
      logic [DataW-1:0] pwr_int;
      bit               good;
      r       = '0;
      good    = (it.address == RegAddr) && (it.access_size == SIZE_WORD);
      pwr_int = DataW'(it.power_interrupt_line) << PwrIntPos;
      case (it.operation)
        OP_READ: begin
          if (good) begin
            r.read_data = ctrl_word | BitPwrOk | pwr_int;
          end else begin
            r.access_error = 1'b1;
          end
        end
        OP_WRITE: begin
          if (good) begin
            prev      = ctrl_word;
            nxt       = it.write_data & WriteMask;
            ctrl_word = nxt;
            if ((prev & (BitVccOn | BitChipSel)) != '0 &&
                (nxt & (BitVccOn | BitChipSel)) == '0) begin
              r.enter_deep_sleep = 1'b1;
            end
            if (nxt[TimerEnPos] && !prev[TimerEnPos]) begin
              ticks_left = nxt[TimerLsb +: CntW];
              if (ticks_left == '0) begin
                armed                  = 1'b0;
                r.stop_timer_interrupt = 1'b1;
              end else begin
                armed = 1'b1;
              end
            end else if (!nxt[TimerEnPos] && prev[TimerEnPos]) begin
              armed = 1'b0;
            end
          end else begin
            r.access_error = 1'b1;
          end
        end
        OP_POWER_UP: begin
          ctrl_word = ctrl_word | BitForceOff | BitChipSel | BitVccOn;
        end
        OP_LATCH_COLD: begin
          cause = CAUSE_COLD;
        end
        OP_LATCH_WARM: begin
          cause = CAUSE_WARM;
        end
        OP_APPLY_RST: begin
          if (cause == CAUSE_COLD) begin
            ctrl_word = ctrl_word | BitCold;
          end else if (cause == CAUSE_WARM) begin
            ctrl_word = ctrl_word & ~BitCold;
          end else begin
            r.access_error = 1'b1;
          end
          cause = CAUSE_NONE;
        end
        OP_TICK: begin
          if (armed) begin
            if (ticks_left <= 1) begin
              ticks_left             = '0;
              armed                  = 1'b0;
              r.stop_timer_interrupt = 1'b1;
            end else begin
              ticks_left = ticks_left - 1'b1;
            end
          end
        end
        default: begin
          r.access_error = 1'b1;
        end
      endcase
      return r;
    endfunction

    function void note_accepted(in_item_t it);
      expected_results.push_back(next_power_result(it));
    endfunction

    function void check_result(res_item_t got);
      res_item_t exp;
      if (expected_results.size() == 0) begin
        report_fault($sformatf("unexpected result transaction rd=%h err=%b sleep=%b irq=%b",
                               got.read_data, got.access_error, got.enter_deep_sleep,
                               got.stop_timer_interrupt));
      end else begin
        exp = expected_results.pop_front();
        if (got.read_data !== exp.read_data || got.access_error !== exp.access_error ||
            got.enter_deep_sleep !== exp.enter_deep_sleep ||
            got.stop_timer_interrupt !== exp.stop_timer_interrupt) begin
          report_fault($sformatf({"result mismatch: expected rd=%h err=%b sleep=%b irq=%b,",
                                  " got rd=%h err=%b sleep=%b irq=%b"},
                                 exp.read_data, exp.access_error, exp.enter_deep_sleep,
                                 exp.stop_timer_interrupt, got.read_data, got.access_error,
                                 got.enter_deep_sleep, got.stop_timer_interrupt));
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_on = 1'b1;
  int unsigned sent_txns = 0;

  pcru_scoreboard sb = new();

  pcru_in_if  in_ch ();
  pcru_out_if out_ch ();

  power_control_register_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  function automatic in_item_t reg_txn(logic [OpW-1:0] op, logic [DataW-1:0] data);
    in_item_t it;
    it.operation            = op;
    it.address              = RegAddr;
    it.access_size          = SIZE_WORD;
    it.write_data           = data;
    it.power_interrupt_line = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_txn(input in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid                <= 1'b1;
    in_ch.operation            <= it.operation;
    in_ch.address              <= it.address;
    in_ch.access_size          <= it.access_size;
    in_ch.write_data           <= it.write_data;
    in_ch.power_interrupt_line <= it.power_interrupt_line;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_accepted(it);
    sent_txns++;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.read_data, out_ch.access_error, out_ch.enter_deep_sleep,
                       out_ch.stop_timer_interrupt});
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_item_t         t;
    logic [DataW-1:0] d;
    int unsigned      n;
    rst_ni                     <= 1'b0;
    in_ch.valid                <= 1'b0;
    in_ch.operation            <= OP_READ;
    in_ch.address              <= '0;
    in_ch.access_size          <= SIZE_WORD;
    in_ch.write_data           <= '0;
    in_ch.power_interrupt_line <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    t = reg_txn(OP_READ, '0);
    t.power_interrupt_line = 1'b0;
    send_txn(t);
    t.power_interrupt_line = 1'b1;
    send_txn(t);
    t.address = ~RegAddr;
    send_txn(t);
    t = reg_txn(OP_READ, '0);
    t.access_size = SIZE_BYTE;
    send_txn(t);
    t = reg_txn(OP_WRITE, '1);
    t.access_size = SIZE_HALF;
    send_txn(t);
    t = reg_txn(OP_WRITE, '1);
    t.address = RegAddr ^ 32'h8000_0000;
    send_txn(t);
    send_txn(reg_txn(OP_POWER_UP, '0));
    send_txn(reg_txn(OP_READ, '0));
    send_txn(reg_txn(OP_WRITE, '1));
    send_txn(reg_txn(OP_TICK, '0));
    send_txn(reg_txn(OP_TICK, '0));
    send_txn(reg_txn(OP_READ, '0));
    send_txn(reg_txn(OP_WRITE, 32'h0000_0800));
    send_txn(reg_txn(OP_WRITE, '0));
    send_txn(reg_txn(OP_WRITE, 32'h0000_0800));
    send_txn(reg_txn(OP_WRITE, '0));
    send_txn(reg_txn(OP_WRITE, 32'h0000_1803));
    send_txn(reg_txn(OP_TICK, '0));
    send_txn(reg_txn(OP_TICK, '0));
    send_txn(reg_txn(OP_LATCH_COLD, '0));
    send_txn(reg_txn(OP_APPLY_RST, '0));
    send_txn(reg_txn(OP_LATCH_WARM, '0));
    send_txn(reg_txn(OP_APPLY_RST, '0));
    send_txn(reg_txn(OP_APPLY_RST, '0));
    send_txn(reg_txn(OP_WATCHDOG, '0));
    send_txn(reg_txn(OP_READ, '0));

    while (sent_txns < TotalTxns) begin
      if (sent_txns >= TotalTxns - CalmTxns) begin
        idle_on = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          d = $urandom;
          d[TimerEnPos] = 1'b0;
          send_txn(reg_txn(OP_WRITE, d));
          d = $urandom;
          d[TimerEnPos] = 1'b1;
          d[TimerLsb +: CntW] = $urandom_range(0, 1) ? CntW'($urandom_range(0, 3))
                                                     : CntW'($urandom_range(0, 15));
          send_txn(reg_txn(OP_WRITE, d));
          n = $urandom_range(0, 18);
          repeat (n) begin
            case ($urandom_range(0, 9))
              0: send_txn(reg_txn(OP_READ, '0));
              1: send_txn(reg_txn(OP_POWER_UP, '0));
              default: send_txn(reg_txn(OP_TICK, '0));
            endcase
          end
          if ($urandom_range(0, 1) == 1) begin
            d = $urandom;
            d[TimerEnPos] = 1'b0;
            send_txn(reg_txn(OP_WRITE, d));
          end
        end
        4, 5: begin
          repeat ($urandom_range(0, 2)) begin
            send_txn(reg_txn($urandom_range(0, 1) ? OP_LATCH_COLD : OP_LATCH_WARM, '0));
          end
          send_txn(reg_txn(OP_APPLY_RST, '0));
          send_txn(reg_txn(OP_READ, '0));
        end
        6, 7: begin
          send_txn(reg_txn(OpW'($urandom_range(0, 7)), $urandom));
        end
        default: begin
          t.operation = OpW'($urandom_range(0, 7));
          case ($urandom_range(0, 2))
            0: t.address = RegAddr;
            1: t.address = RegAddr ^ (32'h1 << $urandom_range(0, 31));
            default: t.address = $urandom;
          endcase
          t.access_size          = SizeW'($urandom_range(0, 2));
          t.write_data           = $urandom;
          t.power_interrupt_line = 1'($urandom_range(0, 1));
          send_txn(t);
        end
      endcase
    end

    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.faults == 0 && sb.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
